### src/gttc_pkg.sv
// ----------------------------------------------------------------------------
// gttc_pkg
// Shared types, column constants and the hex digit decoder for the text line
// to CAN frame receiver.
// ----------------------------------------------------------------------------
package gttc_pkg;

    localparam int MAX_DATA_BYTES_DEF = 8;
    localparam int NUM_BYTE_PORTS     = 8;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_OWN     = 8'h54;

    localparam logic [5:0] COL_MIN_LINE   = 6'd21;
    localparam logic [5:0] COL_OWN        = 6'd13;
    localparam logic [5:0] COL_ID_FIRST   = 6'd15;
    localparam logic [5:0] COL_ID_LAST    = 6'd22;
    localparam int         COL_DATA_FIRST = 24;
    localparam int         SLOT_PITCH     = 3;
    localparam logic [5:0] COL_MAX        = 6'd63;

    localparam logic [1:0] ST_FRAME = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_OWN   = 2'd2;

    typedef struct packed {
        logic [1:0]                           status;
        logic [31:0]                          can_id;
        logic [3:0]                           data_count;
        logic [NUM_BYTE_PORTS-1:0][7:0]       data_bytes;
    } t_result;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

### src/gateway_text_line_to_can_frame_top.sv
// ----------------------------------------------------------------------------
// gateway_text_line_to_can_frame_top
// Parses a text gateway character stream into CAN frame results.
//
// Input channel: one ASCII character per transfer (i_valid / o_stall).
// A newline ends a line; each non-empty line gives one result on the output
// channel (o_valid / i_stall): frame status, identifier, data byte count and
// up to eight data bytes. Short lines and own transmitted lines give only a
// status with all other fields zero.
// A newline is registered in the input register, and its result is loaded
// into the result register once that register is free.
// Throughput: one character per cycle while not stalled; the column compares
// and the hex digit shift all fit in the single step between the two registers.
// Reset clears the line state and both valid flags; no item is in flight.
// While the receiver stalls a waiting result, ordinary characters keep
// flowing; only a newline that ends a line waits in the input register, and
// then o_stall holds further characters back.
// ----------------------------------------------------------------------------
module gateway_text_line_to_can_frame_top #(
    parameter int MAX_DATA_BYTES = gttc_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_can_id,
    output logic [3:0]  o_data_count,
    output logic [7:0]  o_byte_0,
    output logic [7:0]  o_byte_1,
    output logic [7:0]  o_byte_2,
    output logic [7:0]  o_byte_3,
    output logic [7:0]  o_byte_4,
    output logic [7:0]  o_byte_5,
    output logic [7:0]  o_byte_6,
    output logic [7:0]  o_byte_7
);
    import gttc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_char;

    logic    w_emit;
    logic    w_out_free;
    logic    w_advance;
    t_result w_result;
    t_result w_out;

    // a character moves on unless it ends a line and the result register is busy
    assign w_advance = !w_emit || w_out_free;
    assign o_stall   = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_char <= i_char_in;
        end
    end

    gttc_line_parser #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_in_valid),
        .i_advance (w_advance),
        .i_char    (r_char),
        .o_emit    (w_emit),
        .o_result  (w_result)
    );

    gttc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_emit && w_out_free),
        .i_result (w_result),
        .i_stall  (i_stall),
        .o_free   (w_out_free),
        .o_valid  (o_valid),
        .o_result (w_out)
    );

    assign o_status     = w_out.status;
    assign o_can_id     = w_out.can_id;
    assign o_data_count = w_out.data_count;
    assign o_byte_0     = w_out.data_bytes[0];
    assign o_byte_1     = w_out.data_bytes[1];
    assign o_byte_2     = w_out.data_bytes[2];
    assign o_byte_3     = w_out.data_bytes[3];
    assign o_byte_4     = w_out.data_bytes[4];
    assign o_byte_5     = w_out.data_bytes[5];
    assign o_byte_6     = w_out.data_bytes[6];
    assign o_byte_7     = w_out.data_bytes[7];

endmodule

### src/gttc_line_parser.sv
// ----------------------------------------------------------------------------
// gttc_line_parser
// Per-line state: column counter, own-line flag, identifier and data byte
// accumulation. Builds the result word when a line ends.
// ----------------------------------------------------------------------------
module gttc_line_parser #(
    parameter int MAX_DATA_BYTES = gttc_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_advance,
    input  logic [7:0]        i_char,
    output logic              o_emit,
    output gttc_pkg::t_result o_result
);
    import gttc_pkg::*;

    logic [5:0]  r_column,     n_column;
    logic        r_own_line,   n_own_line;
    logic [31:0] r_id_accum,   n_id_accum;
    logic        r_id_open,    n_id_open;
    logic [3:0]  r_byte_count, n_byte_count;
    logic        r_data_open,  n_data_open;
    logic [7:0]  r_data_store [MAX_DATA_BYTES];

    t_hex                     w_hex;
    logic                     w_newline;
    logic                     w_step;
    logic [MAX_DATA_BYTES-1:0] w_wr_first;
    logic [MAX_DATA_BYTES-1:0] w_wr_second;
    logic [MAX_DATA_BYTES-1:0] w_close;
    logic [NUM_BYTE_PORTS-1:0][7:0] w_bytes;

    assign w_hex     = hex_decode(i_char);
    assign w_newline = (i_char == CHAR_NEWLINE);
    assign w_step    = i_valid && i_advance && !w_newline;
    assign o_emit    = i_valid && w_newline && (r_column != 6'd0);

    // one pair of column matches per data slot
    for (genvar i = 0; i < MAX_DATA_BYTES; i++) begin : g_slot
        localparam logic [5:0] COL_FIRST  = 6'(COL_DATA_FIRST + SLOT_PITCH * i);
        localparam logic [5:0] COL_SECOND = 6'(COL_DATA_FIRST + SLOT_PITCH * i + 1);
        logic w_first_hit;
        logic w_second_hit;

        assign w_first_hit  = w_step && r_data_open && (r_column == COL_FIRST)
                              && (r_byte_count == 4'(i));
        assign w_second_hit = w_step && r_data_open && (r_column == COL_SECOND)
                              && (r_byte_count == 4'(i + 1));
        assign w_wr_first[i]  = w_first_hit && w_hex.is_hex;
        assign w_close[i]     = w_first_hit && !w_hex.is_hex;
        assign w_wr_second[i] = w_second_hit && w_hex.is_hex;

        always_ff @(posedge i_clk) begin
            if (w_wr_first[i]) begin
                r_data_store[i] <= {4'd0, w_hex.value};
            end else if (w_wr_second[i]) begin
                r_data_store[i] <= {r_data_store[i][3:0], w_hex.value};
            end
        end
    end

    for (genvar j = 0; j < NUM_BYTE_PORTS; j++) begin : g_byte
        if (j < MAX_DATA_BYTES) begin : g_used
            assign w_bytes[j] = (4'(j) < r_byte_count) ? r_data_store[j] : 8'd0;
        end else begin : g_unused
            assign w_bytes[j] = 8'd0;
        end
    end

    always_comb begin
        o_result = '0;
        if (r_column < COL_MIN_LINE) begin
            o_result.status = ST_SHORT;
        end else if (r_own_line) begin
            o_result.status = ST_OWN;
        end else begin
            o_result.status     = ST_FRAME;
            o_result.can_id     = r_id_accum;
            o_result.data_count = r_byte_count;
            o_result.data_bytes = w_bytes;
        end
    end

    always_comb begin
        n_column     = r_column;
        n_own_line   = r_own_line;
        n_id_accum   = r_id_accum;
        n_id_open    = r_id_open;
        n_byte_count = r_byte_count;
        n_data_open  = r_data_open;
        if (i_valid && i_advance) begin
            if (w_newline) begin
                n_column     = 6'd0;
                n_own_line   = 1'b0;
                n_id_accum   = 32'd0;
                n_id_open    = 1'b1;
                n_byte_count = 4'd0;
                n_data_open  = 1'b1;
            end else begin
                if (r_column == COL_OWN && i_char == CHAR_OWN) begin
                    n_own_line = 1'b1;
                end
                if (r_column >= COL_ID_FIRST && r_column <= COL_ID_LAST && r_id_open) begin
                    if (w_hex.is_hex) begin
                        n_id_accum = {r_id_accum[27:0], w_hex.value};
                    end else begin
                        n_id_open = 1'b0;
                    end
                end
                if (|w_wr_first) begin
                    n_byte_count = r_byte_count + 4'd1;
                end
                if (|w_close) begin
                    n_data_open = 1'b0;
                end
                if (r_column != COL_MAX) begin
                    n_column = r_column + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= 6'd0;
            r_own_line   <= 1'b0;
            r_id_accum   <= 32'd0;
            r_id_open    <= 1'b1;
            r_byte_count <= 4'd0;
            r_data_open  <= 1'b1;
        end else begin
            r_column     <= n_column;
            r_own_line   <= n_own_line;
            r_id_accum   <= n_id_accum;
            r_id_open    <= n_id_open;
            r_byte_count <= n_byte_count;
            r_data_open  <= n_data_open;
        end
    end

endmodule

### src/gttc_out_reg.sv
// ----------------------------------------------------------------------------
// gttc_out_reg
// Result register on the output channel; holds a result until the receiver
// takes it and reports when it can load a new one.
// ----------------------------------------------------------------------------
module gttc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  gttc_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output gttc_pkg::t_result o_result
);
    import gttc_pkg::*;

    logic    r_valid;
    t_result r_result;

    // free when empty or when the held result transfers this cycle
    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### verif/tb_gateway_text_line_to_can_frame_top.sv
// ----------------------------------------------------------------------------
// tb_gateway_text_line_to_can_frame_top
// Self-checking bench for the text line to CAN frame receiver. Lines of
// characters are pushed through the input channel, each accepted character
// runs through a line parser kept in the bench, and every result on the
// output channel is compared field by field with the oldest expected result.
// A short table of hand-written lines comes first, then random gateway
// lines, own transmitted lines, short lines and noise.
// ----------------------------------------------------------------------------
module tb_gateway_text_line_to_can_frame_top;

    timeunit 1ns;
    timeprecision 1ps;

    import gttc_pkg::*;

    localparam int DATA_SLOTS   = MAX_DATA_BYTES_DEF;
    localparam int RANDOM_CHARS = 1300;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int NUM_ROWS     = 17;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_RX    = 8'h52;

    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_NONE,
        ROW_GIVEN
    } t_row_check;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [7:0]  i_char_in    = 8'd0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [31:0] o_can_id;
    logic [3:0]  o_data_count;
    logic [7:0]  o_byte_0;
    logic [7:0]  o_byte_1;
    logic [7:0]  o_byte_2;
    logic [7:0]  o_byte_3;
    logic [7:0]  o_byte_4;
    logic [7:0]  o_byte_5;
    logic [7:0]  o_byte_6;
    logic [7:0]  o_byte_7;

    // line parser state
    logic [5:0]  line_col;
    logic        own_seen;
    logic [31:0] id_acc;
    logic        id_live;
    logic [7:0]  slot_bytes [DATA_SLOTS];
    logic [3:0]  slots_found;
    logic        slots_live;

    t_result     frames_due [$];
    logic [7:0]  line_buf [$];
    int          errors       = 0;
    int          results_seen = 0;
    int          chars_sent   = 0;
    bit          no_idle      = 1'b0;
    bit          sender_done  = 1'b0;

    string row_text [NUM_ROWS] = '{
        "",
        "x",
        "\015",
        "00:00:00.000 T 18EAF",
        "00:00:00.000 R 18EAFF",
        "00:00:00.000 T 18EAFF00 01 02 03",
        "00:00:00.000 R FFFFFFFF FF ff 00 7f 80 aB Cd 9e",
        "00:00:00.000 R 00000000 00 00",
        "00:00:00.000 R 12G45678 01",
        "00:00:00.000 R  1234567 01",
        "00:00:00.000 R 1fffffff 1  2  3\015",
        "00:00:00.000 R 0000ABCD 11 zz 33",
        "00:00:00.000 R 0CF00400 01 02 03 04 05 06 07 08 09 0A",
        "00:00:00.000 R 98FEF100 A1 B2 C3 D4 E5 F6 07 18 trailing text past column 63",
        "00:00:00.000 t 00000001 5",
        "T0:00:00.000 R 00000002 6",
        "00:00:00.000 R 00000003 4g 5"
    };
    t_row_check row_check [NUM_ROWS] = '{
        ROW_NONE, ROW_GIVEN, ROW_GIVEN, ROW_GIVEN, ROW_GIVEN, ROW_GIVEN,
        ROW_GIVEN, ROW_GIVEN, ROW_MODEL, ROW_MODEL, ROW_MODEL, ROW_MODEL,
        ROW_MODEL, ROW_MODEL, ROW_MODEL, ROW_MODEL, ROW_MODEL
    };
    t_result row_given [NUM_ROWS];

    gateway_text_line_to_can_frame_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_in    (i_char_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_can_id     (o_can_id),
        .o_data_count (o_data_count),
        .o_byte_0     (o_byte_0),
        .o_byte_1     (o_byte_1),
        .o_byte_2     (o_byte_2),
        .o_byte_3     (o_byte_3),
        .o_byte_4     (o_byte_4),
        .o_byte_5     (o_byte_5),
        .o_byte_6     (o_byte_6),
        .o_byte_7     (o_byte_7)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] val);
        val = 4'd0;
        if (c >= "0" && c <= "9") begin
            val = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "A" && c <= "F") begin
            val = 4'(c - "A" + 8'd10);
            return 1'b1;
        end
        if (c >= "a" && c <= "f") begin
            val = 4'(c - "a" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void clear_line();
        line_col    = 6'd0;
        own_seen    = 1'b0;
        id_acc      = 32'd0;
        id_live     = 1'b1;
        slots_found = 4'd0;
        slots_live  = 1'b1;
        for (int k = 0; k < DATA_SLOTS; k++) slot_bytes[k] = 8'd0;
    endfunction

    // advance the line parser by one character, report a finished line
    function automatic bit parse_char(input logic [7:0] c, output t_result res);
        logic [3:0] nib;
        bit         is_hex;
        int         ofs;
        int         slot;
        int         pos;
        res    = '0;
        is_hex = hex_digit(c, nib);
        if (c == CHAR_NEWLINE) begin
            if (line_col == 6'd0) return 1'b0;
            if (line_col < COL_MIN_LINE) begin
                res.status = ST_SHORT;
            end else if (own_seen) begin
                res.status = ST_OWN;
            end else begin
                res.status     = ST_FRAME;
                res.can_id     = id_acc;
                res.data_count = slots_found;
                for (int k = 0; k < DATA_SLOTS; k++)
                    if (k < slots_found) res.data_bytes[k] = slot_bytes[k];
            end
            clear_line();
            return 1'b1;
        end
        if (line_col == COL_OWN && c == CHAR_OWN) own_seen = 1'b1;
        if (line_col >= COL_ID_FIRST && line_col <= COL_ID_LAST && id_live) begin
            if (is_hex) id_acc = {id_acc[27:0], nib};
            else        id_live = 1'b0;
        end
        if (int'(line_col) >= COL_DATA_FIRST) begin
            ofs  = int'(line_col) - COL_DATA_FIRST;
            slot = ofs / SLOT_PITCH;
            pos  = ofs % SLOT_PITCH;
            if (slot < DATA_SLOTS && slots_live) begin
                if (pos == 0 && slot == int'(slots_found)) begin
                    if (is_hex) begin
                        slot_bytes[slot] = {4'd0, nib};
                        slots_found      = slots_found + 4'd1;
                    end else begin
                        slots_live = 1'b0;
                    end
                end else if (pos == 1 && int'(slots_found) == slot + 1 && is_hex) begin
                    slot_bytes[slot] = {slot_bytes[slot][3:0], nib};
                end
            end
        end
        if (line_col < COL_MAX) line_col = line_col + 6'd1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] any_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CHAR_NEWLINE);
        return c;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [3:0] nib;
        do c = any_char(); while (hex_digit(c, nib));
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'("0" + n);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 4'd10);
    endfunction

    // gateway style line: stamp, direction tag, identifier, data slots
    function automatic void make_frame_line(input bit own);
        logic [7:0] tag;
        int         slots;
        int         cut;
        line_buf.delete();
        for (int k = 0; k < COL_OWN; k++) line_buf.push_back(any_char());
        tag = any_char();
        if (own) tag = CHAR_OWN;
        else if (tag == CHAR_OWN) tag = CHAR_RX;
        line_buf.push_back(tag);
        line_buf.push_back(CHAR_SPACE);
        for (int k = 0; k < 8; k++)
            line_buf.push_back($urandom_range(0, 15) == 0 ? non_hex_char()
                                                           : hex_char(4'($urandom)));
        line_buf.push_back(CHAR_SPACE);
        slots = $urandom_range(0, DATA_SLOTS + 1);
        for (int s = 0; s < slots; s++) begin
            line_buf.push_back(hex_char(4'($urandom)));
            line_buf.push_back($urandom_range(0, 7) == 0 ? CHAR_SPACE
                                                         : hex_char(4'($urandom)));
            line_buf.push_back($urandom_range(0, 3) == 0 ? any_char() : CHAR_SPACE);
        end
        if ($urandom_range(0, 3) == 0) line_buf.push_back(non_hex_char());
        if ($urandom_range(0, 3) == 0) line_buf.push_back(CHAR_CR);
        // broken line cut off anywhere
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(0, line_buf.size());
            while (line_buf.size() > cut) void'(line_buf.pop_back());
        end
    endfunction

    function automatic void make_noise_line(input int min_len, input int max_len);
        int len;
        line_buf.delete();
        len = $urandom_range(min_len, max_len);
        for (int k = 0; k < len; k++) line_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_char(input logic [7:0] c, input bit from_model);
        t_result res;
        if (!no_idle && $urandom_range(0, 99) < 14) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= c;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
        if (parse_char(c, res) && from_model) frames_due.push_back(res);
    endtask

    task automatic send_line_buf();
        foreach (line_buf[k]) send_char(line_buf[k], 1'b1);
        send_char(CHAR_NEWLINE, 1'b1);
    endtask

    // sender pause until the output side has caught up
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (frames_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("mismatch on %s: expected %h got %h (result %0d)",
                         name, want, got, results_seen);
        end
    endfunction

    function automatic void check_result();
        t_result want;
        t_result got;
        got = '{o_status, o_can_id, o_data_count,
                {o_byte_7, o_byte_6, o_byte_5, o_byte_4,
                 o_byte_3, o_byte_2, o_byte_1, o_byte_0}};
        results_seen++;
        if (frames_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("result %0d with nothing expected: status %0d id %h",
                         results_seen, got.status, got.can_id);
            return;
        end
        want = frames_due.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("can_id", want.can_id, got.can_id);
        check_field("data_count", 32'(want.data_count), 32'(got.data_count));
        for (int k = 0; k < NUM_BYTE_PORTS; k++)
            check_field($sformatf("byte_%0d", k), 32'(want.data_bytes[k]),
                        32'(got.data_bytes[k]));
    endfunction

    // sender
    initial begin
        int         line_no;
        int         pick;
        clear_line();
        foreach (row_given[i]) row_given[i] = '0;
        row_given[1].status = ST_SHORT;
        row_given[2].status = ST_SHORT;
        row_given[3].status = ST_SHORT;
        row_given[4] = '{ST_FRAME, 32'h0018EAFF, 4'd0, '0};
        row_given[5].status = ST_OWN;
        row_given[6] = '{ST_FRAME, 32'hFFFFFFFF, 4'd8,
                         {8'h9E, 8'hCD, 8'hAB, 8'h80, 8'h7F, 8'h00, 8'hFF, 8'hFF}};
        row_given[7] = '{ST_FRAME, 32'h00000000, 4'd2, '0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            for (int k = 0; k < row_text[i].len(); k++)
                send_char(row_text[i][k], 1'b1);
            send_char(CHAR_NEWLINE, row_check[i] == ROW_MODEL);
            if (row_check[i] == ROW_GIVEN) frames_due.push_back(row_given[i]);
        end
        drain();

        line_no    = 0;
        chars_sent = 0;
        while (chars_sent < RANDOM_CHARS) begin
            no_idle = (line_no >= 8 && line_no < 20);
            if (line_no == 26) drain();
            pick = $urandom_range(0, 99);
            if (pick < 60)      make_frame_line(1'b0);
            else if (pick < 70) make_frame_line(1'b1);
            else if (pick < 85) make_noise_line(0, 20);
            else                make_noise_line(21, 80);
            send_line_buf();
            line_no++;
        end
        no_idle = 1'b0;
        drain();
        sender_done = 1'b1;
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("gateway_text_line_to_can_frame_top test passed");
        end else begin
            $display("gateway_text_line_to_can_frame_top test failed");
        end
        $finish;
    end

    // receiver: random stalls, one long hold-off so the input side backs up
    initial begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) check_result();
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!held && results_seen == 20) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                i_stall   <= 1'b1;
            end else if (no_idle || sender_done) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < 22);
            end
        end
    end

    // watchdog: cycles without any transfer on either channel
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("gateway_text_line_to_can_frame_top test failed");
                $finish;
            end
        end
    end

endmodule
